@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed in deframer checker");

// Clocked assertion that also holds across reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed in deframer checker");

`endif

@@ rtl/core/h3fd_pkg.sv @@
// Package with the types, constants and helpers of the HTTP/3 frame deframer.
package h3fd_pkg;

    localparam int unsigned KindW = 62;
    localparam int unsigned ByteW = 8;
    localparam int unsigned LeftW = 3;

    localparam logic [KindW-1:0] KIND_HEADERS = 62'd1;
    localparam logic [5:0]       VI_LOW_MASK  = 6'h3f;
    localparam int unsigned      VI_SIZE_SHIFT = 6;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        logic [KindW-1:0] frame_kind;
        logic [ByteW-1:0] payload_byte;
        logic             carries_byte;
        logic             frame_end;
        logic             headers_seen;
    } t_res;

    // Number of bytes that follow the first byte of a variable-length integer.
    function automatic logic [LeftW-1:0] vi_extra(input logic [1:0] size_code);
        logic [LeftW-1:0] extra;
        case (size_code)
            2'd0:    extra = 3'd0;
            2'd1:    extra = 3'd1;
            2'd2:    extra = 3'd3;
            default: extra = 3'd7;
        endcase
        return extra;
    endfunction

endpackage

@@ rtl/core/h3fd_core.sv @@
// Input register, frame header decoder and payload counter of the deframer.
module h3fd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [h3fd_pkg::ByteW-1:0]     i_data_byte,
    input  logic                           i_space,
    output logic                           o_push,
    output h3fd_pkg::t_res                 o_res
);

    logic                          r_in_valid;
    logic [h3fd_pkg::ByteW-1:0]    r_in_byte;
    h3fd_pkg::t_phase              r_phase, n_phase;
    logic [h3fd_pkg::KindW-1:0]    r_acc, n_acc;
    logic [h3fd_pkg::LeftW-1:0]    r_left, n_left;
    logic [h3fd_pkg::KindW-1:0]    r_kind, n_kind;
    logic [h3fd_pkg::KindW-1:0]    r_rem, n_rem;
    logic                          r_flag, n_flag;

    logic                          advance;
    logic                          accept;
    logic [h3fd_pkg::KindW-1:0]    feed_acc;
    logic [h3fd_pkg::LeftW-1:0]    feed_left;
    logic                          feed_done;

    // The input register drains whenever the result side has room.
    assign advance = r_in_valid && i_space;
    assign o_stall = r_in_valid && !i_space;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    // A new integer starts with its size code and six value bits.
    always_comb begin
        if (r_left == '0) begin
            feed_acc  = {{(h3fd_pkg::KindW-6){1'b0}},
                         r_in_byte[5:0] & h3fd_pkg::VI_LOW_MASK};
            feed_left = h3fd_pkg::vi_extra(r_in_byte[h3fd_pkg::VI_SIZE_SHIFT +: 2]);
        end else begin
            feed_acc  = {r_acc[h3fd_pkg::KindW-h3fd_pkg::ByteW-1:0], r_in_byte};
            feed_left = r_left - 3'd1;
        end
        feed_done = (feed_left == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= h3fd_pkg::PH_TYPE;
            r_left  <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_flag  <= n_flag;
        end
        r_acc  <= n_acc;
        r_kind <= n_kind;
        r_rem  <= n_rem;
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_left  = r_left;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_flag  = r_flag;
        o_push  = 1'b0;
        o_res.payload_byte = r_in_byte;
        o_res.carries_byte = 1'b1;
        o_res.frame_end    = 1'b0;
        if (advance) begin
            case (r_phase)
                h3fd_pkg::PH_PAYLOAD: begin
                    n_rem  = r_rem - 62'd1;
                    o_push = 1'b1;
                    if (n_rem == '0) begin
                        o_res.frame_end = 1'b1;
                        n_phase = h3fd_pkg::PH_TYPE;
                    end
                end
                h3fd_pkg::PH_LEN: begin
                    n_acc  = feed_acc;
                    n_left = feed_left;
                    if (feed_done) begin
                        n_rem = feed_acc;
                        n_acc = '0;
                        if (r_kind == h3fd_pkg::KIND_HEADERS) begin
                            n_flag = 1'b1;
                        end
                        if (feed_acc == '0) begin
                            // Zero-length frame: report the end without a byte.
                            o_push = 1'b1;
                            o_res.payload_byte = '0;
                            o_res.carries_byte = 1'b0;
                            o_res.frame_end    = 1'b1;
                            n_phase = h3fd_pkg::PH_TYPE;
                        end else begin
                            n_phase = h3fd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    n_phase = h3fd_pkg::PH_TYPE;
                    n_acc   = feed_acc;
                    n_left  = feed_left;
                    if (feed_done) begin
                        n_kind  = feed_acc;
                        n_acc   = '0;
                        n_phase = h3fd_pkg::PH_LEN;
                    end
                end
            endcase
        end
        o_res.frame_kind   = r_kind;
        o_res.headers_seen = n_flag;
    end

endmodule

@@ rtl/core/h3fd_obuf.sv @@
// Result register with a skid stage that absorbs one result while the receiver stalls.
module h3fd_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  h3fd_pkg::t_res i_res,
    output logic           o_space,
    output logic           o_valid,
    output h3fd_pkg::t_res o_res,
    input  logic           i_stall
);

    logic           r_main_valid;
    logic           r_skid_valid;
    h3fd_pkg::t_res r_main;
    h3fd_pkg::t_res r_skid;
    logic           main_free;

    // Room is taken from registered state only, so no path runs from stall to stall.
    assign o_space   = !r_skid_valid;
    assign main_free = !r_main_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

@@ rtl/core/http3_frame_deframer.sv @@
// HTTP/3 frame deframer: splits a byte stream into typed payload bytes.
//
// Input channel: one stream byte per request on i_data_byte, taken at a
// clock edge where i_valid is high and o_stall is low.
// Output channel: one result per payload byte, or a single result with
// o_carries_byte low for a frame of zero length. o_frame_end marks the last
// result of a frame, o_frame_kind gives the frame type and o_headers_seen
// stays high once a HEADERS frame header has been read.
// Header bytes (type and length integers) produce no result.
// Timing: a byte taken at one edge is decoded while it sits in the input
// register, and its result is loaded into the result register once the
// result side has room. o_valid rises when the result register is loaded.
// Throughput: one byte per cycle while the result side has room; the decode
// and the decrement of the 62-bit payload counter act on the input register.
// When the receiver stalls, a skid stage absorbs one more result; after
// that o_stall rises and the input register holds its byte.
// Reset (synchronous, active low) empties the input, result and skid registers
// and returns the parser to reading a frame type with the HEADERS flag cleared.
module http3_frame_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [h3fd_pkg::ByteW-1:0] i_data_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [h3fd_pkg::KindW-1:0] o_frame_kind,
    output logic [h3fd_pkg::ByteW-1:0] o_payload_byte,
    output logic                       o_carries_byte,
    output logic                       o_frame_end,
    output logic                       o_headers_seen
);

    logic           push;
    logic           space;
    h3fd_pkg::t_res core_res;
    h3fd_pkg::t_res out_res;

    h3fd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_space     (space),
        .o_push      (push),
        .o_res       (core_res)
    );

    h3fd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (core_res),
        .o_space (space),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_stall (i_stall)
    );

    assign o_frame_kind   = out_res.frame_kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_carries_byte = out_res.carries_byte;
    assign o_frame_end    = out_res.frame_end;
    assign o_headers_seen = out_res.headers_seen;

endmodule

@@ rtl/core/h3fd_checker.sv @@
// Port-level checker for the deframer and its bind to the top level.
`include "assert_macros.svh"

module h3fd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       o_stall,
    input  logic [h3fd_pkg::ByteW-1:0] i_data_byte,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  logic [h3fd_pkg::KindW-1:0] o_frame_kind,
    input  logic [h3fd_pkg::ByteW-1:0] o_payload_byte,
    input  logic                       o_carries_byte,
    input  logic                       o_frame_end,
    input  logic                       o_headers_seen
);

    logic [h3fd_pkg::KindW+h3fd_pkg::ByteW+2:0] res_word;
    logic                                       empty_ok;
    logic                                       in_held;

    assign res_word = {o_frame_kind, o_payload_byte, o_carries_byte, o_frame_end,
                       o_headers_seen};
    assign empty_ok = o_frame_end && (o_payload_byte == '0);
    assign in_held  = i_valid && o_stall;

    // Reset leaves no result pending and no request blocked.
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)

    // A result held by the receiver keeps its fields.
    `ASSERT_CLK_RST(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(res_word))

    // A stalled request stays valid with the same byte.
    `ASSERT_CLK_RST(a_in_hold, i_clk, i_rst_n, in_held |=> i_valid && $stable(i_data_byte))

    // An empty-frame event always ends its frame and carries a zero byte.
    `ASSERT_CLK_RST(a_empty_end, i_clk, i_rst_n, o_valid && !o_carries_byte |-> empty_ok)

    // The HEADERS flag never falls between results.
    `ASSERT_CLK_RST(a_flag_sticky, i_clk, i_rst_n, o_valid && o_headers_seen |=> o_headers_seen)

endmodule

bind http3_frame_deframer h3fd_checker u_h3fd_checker (.*);
